// ===== rtl/core/crc8_frame_checker_macros.svh =====
// Assertion macros for the CRC-8 frame checker.
// Define NO_ASSERTIONS to compile every check away.
`ifndef CRC8_FRAME_CHECKER_MACROS_SVH
`define CRC8_FRAME_CHECKER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CRC8FC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc8fc: check failed");
// next-cycle implication
`define CRC8FC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc8fc: check failed");
`else
`define CRC8FC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CRC8FC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/crc8fc_pkg.sv =====
// Shared types and constants of the CRC-8 frame checker.
// No dependencies; used by the channel interfaces and the top level.
package crc8fc_pkg;

  localparam int unsigned MaxPayloadDef = 32;
  localparam logic [7:0]  CrcPoly       = 8'h07;
  localparam logic [5:0]  DoneIndex     = 6'd63;
  localparam logic [5:0]  FrameLenRst   = 6'd32;
  localparam logic [2:0]  LastCrcBit    = 3'd7;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_BAD_CRC   = 2'd3
  } status_e;

  typedef enum logic {
    REG_START_BYTE = 1'b0,
    REG_FRAME_LEN  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    status_e    status;
    logic       last;
  } out_word_t;

  typedef struct packed {
    cfg_reg_e   index;
    logic [7:0] data;
  } cfg_word_t;

  // one MSB-first step of the CRC shift register
  function automatic logic [7:0] crc8_bit_step(input logic [7:0] c);
    logic [7:0] sh;
    sh = {c[6:0], 1'b0};
    return c[7] ? (sh ^ CrcPoly) : sh;
  endfunction

endpackage

// ===== rtl/core/crc8fc_in_if.sv =====
// Received-byte channel of the CRC-8 frame checker.
// Depends on crc8fc_pkg for the word type.
interface crc8fc_in_if import crc8fc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/crc8fc_out_if.sv =====
// Result channel of the CRC-8 frame checker.
// Depends on crc8fc_pkg for the word type.
interface crc8fc_out_if import crc8fc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/crc8fc_cfg_if.sv =====
// Register write channel of the CRC-8 frame checker.
// Depends on crc8fc_pkg for the word type.
interface crc8fc_cfg_if import crc8fc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/crc8_frame_checker.sv =====
// Start/length/payload/CRC-8 frame checker. Start and length bytes are each taken in S_IDLE.
// Payload byte: accepted in S_IDLE, then shifted through the 1-bit CRC shift unit in S_CRC.
// CRC byte: an error word goes out via S_ERR; an ok packet drains via S_RD (store read) and S_EMIT per word.
// Reset clears control state, start_byte to 0 and frame_len to 32; the payload
// store is not cleared. Depends on crc8fc_pkg, the channel interfaces and macros.
`include "crc8_frame_checker_macros.svh"

module crc8_frame_checker import crc8fc_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  crc8fc_cfg_if.sink    cfg_i,
  crc8fc_in_if.sink     in_i,
  crc8fc_out_if.source  out_o
);

  localparam int unsigned AddrW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [5:0]  MaxLen = 6'(MAX_PAYLOAD);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CRC  = 5'b00010,
    S_ERR  = 5'b00100,
    S_RD   = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [7:0]         start_byte_q;
  logic [5:0]         frame_len_q;
  logic [5:0]         byte_idx_q, byte_idx_d;
  logic [7:0]         crc_q, crc_d;
  status_e            err_q, err_d;
  logic [2:0]         bit_cnt_q, bit_cnt_d;
  logic [AddrW-1:0]   emit_idx_q, emit_idx_d;
  logic [7:0]         rd_data_q;
  logic [7:0]         mem [MAX_PAYLOAD];
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;

  logic               in_acc;
  logic [7:0]         rx_b;
  logic [5:0]         pos;
  logic [5:0]         pos_m2;
  logic [5:0]         eff_len;
  logic [5:0]         len_p2;
  logic               pos_live;
  logic               is_payload;
  logic               slot_free;
  logic               emit_last;
  logic               mem_we;
  logic [AddrW-1:0]   slot_addr;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid & in_i.ready;
  assign rx_b        = in_i.payload.rx_byte;

  // saturate frame_len into 1..MAX_PAYLOAD
  always_comb begin
    if (frame_len_q == 6'd0) begin
      eff_len = 6'd1;
    end else if (frame_len_q > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = frame_len_q;
    end
  end

  assign len_p2     = eff_len + 6'd2;
  assign pos        = in_i.payload.first_of_packet ? 6'd0 : byte_idx_q;
  assign pos_m2     = pos - 6'd2;
  assign slot_addr  = pos_m2[AddrW-1:0];
  assign pos_live   = (pos != DoneIndex) && (pos <= len_p2);
  assign is_payload = pos_live && (pos > 6'd1) && (pos < len_p2);
  assign mem_we     = in_acc && is_payload;
  assign slot_free  = !out_valid_q || out_o.ready;
  assign emit_last  = (6'(emit_idx_q) == (eff_len - 6'd1));

  always_comb begin
    state_d     = state_q;
    byte_idx_d  = byte_idx_q;
    crc_d       = crc_q;
    err_d       = err_q;
    bit_cnt_d   = bit_cnt_q;
    emit_idx_d  = emit_idx_q;
    out_word_d  = out_word_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    case (state_q)
      S_IDLE: begin
        if (in_acc && pos_live) begin
          if (pos == 6'd0) begin
            crc_d      = 8'h00;
            err_d      = (rx_b != start_byte_q) ? ST_BAD_START : ST_OK;
            byte_idx_d = 6'd1;
          end else if (pos == 6'd1) begin
            if (err_q == ST_OK && rx_b != {2'b00, eff_len}) begin
              err_d = ST_BAD_LEN;
            end
            byte_idx_d = 6'd2;
          end else if (is_payload) begin
            // fold the byte in, then shift it through one bit a cycle
            crc_d      = crc_q ^ rx_b;
            bit_cnt_d  = 3'd0;
            byte_idx_d = pos + 6'd1;
            state_d    = S_CRC;
          end else begin
            byte_idx_d = DoneIndex;
            if (err_q == ST_OK && rx_b != crc_q) begin
              err_d   = ST_BAD_CRC;
              state_d = S_ERR;
            end else if (err_q != ST_OK) begin
              state_d = S_ERR;
            end else begin
              emit_idx_d = '0;
              state_d    = S_RD;
            end
          end
        end
      end
      S_CRC: begin
        crc_d     = crc8_bit_step(crc_q);
        bit_cnt_d = bit_cnt_q + 3'd1;
        if (bit_cnt_q == LastCrcBit) begin
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_word_d.data_byte = 8'h00;
          out_word_d.status    = err_q;
          out_word_d.last      = 1'b1;
          state_d              = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_word_d.data_byte = rd_data_q;
          out_word_d.status    = ST_OK;
          out_word_d.last      = emit_last;
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + AddrW'(1);
            state_d    = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      byte_idx_q   <= 6'd0;
      crc_q        <= 8'h00;
      err_q        <= ST_OK;
      bit_cnt_q    <= 3'd0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      start_byte_q <= 8'h00;
      frame_len_q  <= FrameLenRst;
    end else begin
      state_q     <= state_d;
      byte_idx_q  <= byte_idx_d;
      crc_q       <= crc_d;
      err_q       <= err_d;
      bit_cnt_q   <= bit_cnt_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.payload.index)
          REG_START_BYTE: start_byte_q <= cfg_i.payload.data;
          REG_FRAME_LEN:  frame_len_q  <= cfg_i.payload.data[5:0];
          default: ;
        endcase
      end
    end
  end

  // payload store and output word hold no reset
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_addr] <= rx_b;
    end
    rd_data_q  <= mem[emit_idx_q];
    out_word_q <= out_word_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

  `CRC8FC_ASSERT_NEXT(a_payload_runs_crc, clk_i, rst_ni, mem_we, state_q == S_CRC)
  `CRC8FC_ASSERT_NEXT(a_crc_ends_idle, clk_i, rst_ni,
    (state_q == S_CRC) && (bit_cnt_q == LastCrcBit), state_q == S_IDLE)
  `CRC8FC_ASSERT_SAME(a_emit_in_range, clk_i, rst_ni,
    state_q == S_EMIT, 6'(emit_idx_q) < eff_len)
  `CRC8FC_ASSERT_SAME(a_error_is_last, clk_i, rst_ni,
    out_valid_q && (out_word_q.status != ST_OK), out_word_q.last)

endmodule

// ===== tb/sv/crc8_frame_checker_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for crc8_frame_checker: a directed table of words, then random packets
// under three idle patterns, each result checked against a table word or an in-bench frame predictor.
// Depends on crc8fc_pkg, the three channel interfaces and the crc8_frame_checker top level.
module crc8_frame_checker_test;
  import crc8fc_pkg::*;

  localparam int unsigned SettleCycles = 24;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned LogCap       = 100;
  localparam int unsigned RunLimitNs   = 2_000_000;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_BYTE,
    ROW_CRC_OK,
    ROW_CRC_BAD
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    cfg_reg_e   sel;
    logic       first;
    logic [7:0] value;
    logic       typed;
    out_word_t  want;
  } stim_row_t;

  // value is the register data for ROW_CFG and the CRC corruption mask for ROW_CRC_BAD
  localparam stim_row_t DirectedRows [31] = '{
    '{ROW_CFG,     REG_START_BYTE, 1'b0, 8'hA5, 1'b0, '0},
    '{ROW_CFG,     REG_FRAME_LEN,  1'b0, 8'h01, 1'b0, '0},
    // first packet after reset carries no marker
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'hA5, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h01, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'hFF, 1'b0, '0},
    '{ROW_CRC_OK,  REG_START_BYTE, 1'b0, 8'h00, 1'b1, '{8'hFF, ST_OK, 1'b1}},
    // wrong start byte
    '{ROW_BYTE,    REG_START_BYTE, 1'b1, 8'h00, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h01, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h00, 1'b0, '0},
    '{ROW_CRC_OK,  REG_START_BYTE, 1'b0, 8'h00, 1'b1, '{8'h00, ST_BAD_START, 1'b1}},
    // wrong length byte
    '{ROW_BYTE,    REG_START_BYTE, 1'b1, 8'hA5, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h02, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h80, 1'b0, '0},
    '{ROW_CRC_OK,  REG_START_BYTE, 1'b0, 8'h00, 1'b1, '{8'h00, ST_BAD_LEN, 1'b1}},
    // packet cut short by the next marker
    '{ROW_BYTE,    REG_START_BYTE, 1'b1, 8'hA5, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h01, 1'b0, '0},
    // wrong CRC
    '{ROW_BYTE,    REG_START_BYTE, 1'b1, 8'hA5, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h01, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h7F, 1'b0, '0},
    '{ROW_CRC_BAD, REG_START_BYTE, 1'b0, 8'h01, 1'b1, '{8'h00, ST_BAD_CRC, 1'b1}},
    // start, length and CRC all wrong: start wins
    '{ROW_BYTE,    REG_START_BYTE, 1'b1, 8'h5A, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h00, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h01, 1'b0, '0},
    '{ROW_CRC_BAD, REG_START_BYTE, 1'b0, 8'h80, 1'b1, '{8'h00, ST_BAD_START, 1'b1}},
    // trailing words after the CRC byte
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h3C, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'hC3, 1'b0, '0},
    // zero length saturates to one
    '{ROW_CFG,     REG_FRAME_LEN,  1'b0, 8'h00, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b1, 8'hA5, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h01, 1'b0, '0},
    '{ROW_BYTE,    REG_START_BYTE, 1'b0, 8'h5B, 1'b0, '0},
    '{ROW_CRC_OK,  REG_START_BYTE, 1'b0, 8'h00, 1'b1, '{8'h5B, ST_OK, 1'b1}}
  };

  localparam logic [7:0] PhaseStart [NumPhases] = '{8'h00, 8'hFF, 8'h7E, 8'h81, 8'hA5, 8'h5A};
  localparam logic [7:0] PhaseLen   [NumPhases] = '{8'h00, 8'h02, 8'h3F, 8'h03, 8'hC5, 8'h21};

  logic clk_i;
  logic rst_ni;

  crc8fc_cfg_if cfg_if ();
  crc8fc_in_if  in_if ();
  crc8fc_out_if out_if ();

  crc8_frame_checker uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor copy of the registers and the packet state
  logic [7:0] cfg_start;
  logic [5:0] cfg_len;
  logic [5:0] byte_pos_q;
  logic [7:0] crc_acc_q;
  status_e    first_err_q;
  logic [7:0] payload_q [MaxPayloadDef];

  out_word_t   pending_words [$];
  out_word_t   step_words [$];
  out_word_t   want_word;
  int unsigned mismatch_cnt;
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  int unsigned phase_items;
  int unsigned phase_packets;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("crc8_frame_checker regression: fail");
    $finish;
  end

  function automatic int unsigned payload_len();
    if (cfg_len == 6'd0) begin
      return 1;
    end
    if (cfg_len > MaxPayloadDef) begin
      return MaxPayloadDef;
    end
    return cfg_len;
  endfunction

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // advance the packet state by one word; results land in step_words
  function automatic void advance_frame(input in_word_t w);
    int unsigned len;
    int unsigned pos;
    out_word_t   r;
    step_words.delete();
    len = payload_len();
    if (w.first_of_packet) begin
      byte_pos_q  = 6'd0;
      crc_acc_q   = 8'd0;
      first_err_q = ST_OK;
    end
    pos = byte_pos_q;
    if (byte_pos_q == DoneIndex || pos > len + 2) begin
      return;
    end
    if (pos == 0) begin
      crc_acc_q   = 8'd0;
      first_err_q = (w.rx_byte != cfg_start) ? ST_BAD_START : ST_OK;
      byte_pos_q  = 6'd1;
    end else if (pos == 1) begin
      if (first_err_q == ST_OK && w.rx_byte != len) begin
        first_err_q = ST_BAD_LEN;
      end
      byte_pos_q = 6'd2;
    end else if (pos < len + 2) begin
      payload_q[pos - 2] = w.rx_byte;
      crc_acc_q          = crc8_next(crc_acc_q, w.rx_byte);
      byte_pos_q         = 6'(pos + 1);
    end else begin
      byte_pos_q = DoneIndex;
      if (first_err_q == ST_OK && w.rx_byte != crc_acc_q) begin
        first_err_q = ST_BAD_CRC;
      end
      if (first_err_q != ST_OK) begin
        r.data_byte = 8'd0;
        r.status    = first_err_q;
        r.last      = 1'b1;
        step_words.push_back(r);
      end else begin
        for (int i = 0; i < len; i++) begin
          r.data_byte = payload_q[i];
          r.status    = ST_OK;
          r.last      = (i + 1 == len);
          step_words.push_back(r);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    // cap the log
    if (mismatch_cnt <= LogCap) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_byte(input in_word_t w, input logic typed, input out_word_t want);
    while ($urandom_range(99) < in_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    advance_frame(w);
    if (typed) begin
      pending_words.push_back(want);
    end else begin
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
    end
    phase_items++;
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e sel, input logic [7:0] value);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: sel, data: value};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (sel == REG_START_BYTE) begin
      cfg_start = value;
    end else begin
      cfg_len = value[5:0];
    end
    @(negedge clk_i);
  endtask

  // hold input until every result is out and a trailing payload word has settled
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic send_random_packet();
    int unsigned kind;
    int unsigned len;
    int unsigned nbytes;
    logic [7:0]  b;
    kind = $urandom_range(99);
    len  = payload_len();
    if (kind >= 94) begin
      // stray words with random markers
      repeat ($urandom_range(4, 1)) send_byte({8'($urandom), 1'($urandom)}, 1'b0, '0);
      return;
    end
    // cut-short packets stop anywhere before the CRC byte
    nbytes = (kind >= 88) ? $urandom_range(len + 2, 1) : len + 3;
    for (int k = 0; k < nbytes; k++) begin
      if (k == 0) begin
        b = cfg_start;
        if (kind >= 60 && kind < 70) b ^= 8'($urandom_range(255, 1));
      end else if (k == 1) begin
        b = 8'(len);
        if (kind >= 70 && kind < 78) b ^= 8'($urandom_range(255, 1));
      end else if (k < len + 2) begin
        b = 8'($urandom);
      end else begin
        b = crc_acc_q;
        if (kind >= 78 && kind < 88) b ^= 8'($urandom_range(255, 1));
      end
      send_byte({b, (k == 0)}, 1'b0, '0);
    end
    phase_packets++;
    if (kind < 88 && $urandom_range(99) < 15) begin
      repeat ($urandom_range(2, 1)) send_byte({8'($urandom), 1'b0}, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word %h with none expected", out_if.payload));
      end else begin
        want_word = pending_words.pop_front();
        if (out_if.payload.data_byte !== want_word.data_byte) begin
          report_mismatch($sformatf("data_byte %h, expected %h",
                                    out_if.payload.data_byte, want_word.data_byte));
        end
        if (out_if.payload.status !== want_word.status) begin
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_if.payload.status, want_word.status));
        end
        if (out_if.payload.last !== want_word.last) begin
          report_mismatch($sformatf("last %b, expected %b",
                                    out_if.payload.last, want_word.last));
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    out_if.ready   = 1'b0;
    cfg_start      = 8'd0;
    cfg_len        = FrameLenRst;
    byte_pos_q     = 6'd0;
    crc_acc_q      = 8'd0;
    first_err_q    = ST_OK;
    mismatch_cnt   = 0;
    in_gap_pct     = 11;
    out_stall_pct  = 49;
    phase_items    = 0;
    phase_packets  = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      case (row.kind)
        ROW_CFG: begin
          drain_results();
          cfg_write(row.sel, row.value);
          cfg_if.valid <= 1'b0;
        end
        ROW_BYTE:    send_byte({row.value, row.first}, row.typed, row.want);
        ROW_CRC_OK:  send_byte({crc_acc_q, 1'b0}, row.typed, row.want);
        ROW_CRC_BAD: send_byte({crc_acc_q ^ row.value, 1'b0}, row.typed, row.want);
        default:     ;
      endcase
    end

    for (int p = 0; p < NumPhases; p++) begin
      in_gap_pct    = (p < 2) ? 11 : (p < 4) ? 49 : 0;
      out_stall_pct = (p < 2) ? 49 : (p < 4) ? 11 : 0;
      drain_results();
      cfg_write(REG_START_BYTE, PhaseStart[p]);
      cfg_write(REG_FRAME_LEN, PhaseLen[p]);
      cfg_if.valid <= 1'b0;
      phase_items   = 0;
      phase_packets = 0;
      while (phase_items < 25 || phase_packets < 1) send_random_packet();
    end

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("crc8_frame_checker regression: pass");
    end else begin
      $display("crc8_frame_checker regression: fail");
    end
    $finish;
  end

endmodule
